@@ sv/one_line_pulse_width_word_sender_unit_macros.svh @@
// ----------------------------------------------------------------------------
// One-line pulse-width word sender: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ONE_LINE_PULSE_WIDTH_WORD_SENDER_UNIT_MACROS_SVH
`define ONE_LINE_PULSE_WIDTH_WORD_SENDER_UNIT_MACROS_SVH

// same-cycle implication
`define OLPWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olpws assertion failed");

// next-cycle implication
`define OLPWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olpws assertion failed");

`endif

@@ sv/olpws_pkg.sv @@
// ----------------------------------------------------------------------------
// One-line pulse-width word sender: package
// Widths, register indexes, reset values and the result beat type.
// ----------------------------------------------------------------------------
package olpws_pkg;

   localparam int unsigned CfgWidth  = 17;
   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned WordWidth = 16;

   localparam logic [IdxWidth-1:0] REG_START_LOW   = 3'd0;
   localparam logic [IdxWidth-1:0] REG_LONG_PULSE  = 3'd1;
   localparam logic [IdxWidth-1:0] REG_SHORT_PULSE = 3'd2;
   localparam logic [IdxWidth-1:0] REG_BYTE_GAP    = 3'd3;
   localparam logic [IdxWidth-1:0] REG_END_GAP     = 3'd4;

   localparam logic [CfgWidth-1:0] START_LOW_RST   = 17'd5000;
   localparam logic [CfgWidth-1:0] LONG_PULSE_RST  = 17'd600;
   localparam logic [CfgWidth-1:0] SHORT_PULSE_RST = 17'd200;
   localparam logic [CfgWidth-1:0] BYTE_GAP_RST    = 17'd2000;
   localparam logic [CfgWidth-1:0] END_GAP_RST     = 17'd100000;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_type;

endpackage

@@ sv/one_line_pulse_width_word_sender_unit.sv @@
// ----------------------------------------------------------------------------
// One-line pulse-width word sender
// Sends a 16-bit word over an idle-high line as two pulse-width coded bytes.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_ready is high: each beat is a time tick or a
// send request, and each gives exactly one result beat. The frame state
// (phase, down counter, bit position) is updated once per accepted beat;
// a two-entry output stage (result register plus skid register) keeps the
// input open for one more beat while a result waits, so the input stalls only
// when both entries are full. Duration registers of zero act as one tick.

module one_line_pulse_width_word_sender_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [olpws_pkg::WordWidth-1:0]   req_data_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_line_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_frame_done,
   output logic                              rsp_rejected,
   input  logic                              csr_we,
   input  logic [olpws_pkg::IdxWidth-1:0]    csr_index,
   input  logic [olpws_pkg::CfgWidth-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_BIT_HIGH,
      PH_BIT_LOW,
      PH_BYTE_GAP,
      PH_END_GAP
   } phase_type;

   logic [olpws_pkg::CfgWidth-1:0]  start_low_ff, long_pulse_ff, short_pulse_ff;
   logic [olpws_pkg::CfgWidth-1:0]  byte_gap_ff, end_gap_ff;

   phase_type                       phase_ff, phase_in;
   logic [olpws_pkg::CfgWidth-1:0]  time_left_ff, time_left_in;
   logic [2:0]                      bit_pos_ff, bit_pos_in;
   logic                            second_ff, second_in;
   logic [olpws_pkg::WordWidth-1:0] word_ff, word_in;
   logic                            line_ff, line_in;

   logic                            out_valid_ff, out_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   olpws_pkg::rsp_type              out_ff, out_in;
   olpws_pkg::rsp_type              skid_ff, skid_in;
   olpws_pkg::rsp_type              res;

   logic                            accept;
   logic                            out_free;
   logic                            done;
   logic                            rej;
   logic [2:0]                      pos_next;

   function automatic logic pick_bit(input logic [15:0] w, input logic sec,
                                     input logic [2:0] pos);
      logic [7:0] b;
      b = sec ? w[7:0] : w[15:8];
      return b[pos];
   endfunction

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign pos_next  = bit_pos_ff + 3'd1;

   always_comb begin
      phase_in     = phase_ff;
      time_left_in = time_left_ff;
      bit_pos_in   = bit_pos_ff;
      second_in    = second_ff;
      word_in      = word_ff;
      line_in      = line_ff;
      done         = 1'b0;
      rej          = 1'b0;
      if (req_kind) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            word_in      = req_data_word;
            second_in    = 1'b0;
            bit_pos_in   = 3'd0;
            phase_in     = PH_START;
            time_left_in = start_low_ff;
            line_in      = 1'b0;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (time_left_ff > 17'd1) begin
            time_left_in = time_left_ff - 17'd1;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  bit_pos_in   = 3'd0;
                  phase_in     = PH_BIT_HIGH;
                  time_left_in = pick_bit(word_ff, second_ff, 3'd0) ? long_pulse_ff
                                                                     : short_pulse_ff;
                  line_in      = 1'b1;
               end
               PH_BIT_HIGH: begin
                  phase_in     = PH_BIT_LOW;
                  time_left_in = pick_bit(word_ff, second_ff, bit_pos_ff) ? short_pulse_ff
                                                                         : long_pulse_ff;
                  line_in      = 1'b0;
               end
               PH_BIT_LOW: begin
                  line_in = 1'b1;
                  if (bit_pos_ff == 3'd7) begin
                     phase_in     = second_ff ? PH_END_GAP : PH_BYTE_GAP;
                     time_left_in = second_ff ? end_gap_ff : byte_gap_ff;
                  end else begin
                     bit_pos_in   = pos_next;
                     phase_in     = PH_BIT_HIGH;
                     time_left_in = pick_bit(word_ff, second_ff, pos_next) ? long_pulse_ff
                                                                          : short_pulse_ff;
                  end
               end
               PH_BYTE_GAP: begin
                  second_in    = 1'b1;
                  bit_pos_in   = 3'd0;
                  phase_in     = PH_START;
                  time_left_in = start_low_ff;
                  line_in      = 1'b0;
               end
               PH_END_GAP: begin
                  phase_in     = PH_IDLE;
                  time_left_in = '0;
                  bit_pos_in   = 3'd0;
                  second_in    = 1'b0;
                  line_in      = 1'b1;
                  done         = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      res.line_level = line_in;
      res.busy_res   = (phase_in != PH_IDLE);
      res.frame_done = done;
      res.rejected   = rej;
   end

   // result register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         time_left_ff  <= '0;
         bit_pos_ff    <= 3'd0;
         second_ff     <= 1'b0;
         word_ff       <= '0;
         line_ff       <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            time_left_ff <= time_left_in;
            bit_pos_ff   <= bit_pos_in;
            second_ff    <= second_in;
            word_ff      <= word_in;
            line_ff      <= line_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff   <= olpws_pkg::START_LOW_RST;
         long_pulse_ff  <= olpws_pkg::LONG_PULSE_RST;
         short_pulse_ff <= olpws_pkg::SHORT_PULSE_RST;
         byte_gap_ff    <= olpws_pkg::BYTE_GAP_RST;
         end_gap_ff     <= olpws_pkg::END_GAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            olpws_pkg::REG_START_LOW:   start_low_ff   <= csr_wdata;
            olpws_pkg::REG_LONG_PULSE:  long_pulse_ff  <= csr_wdata;
            olpws_pkg::REG_SHORT_PULSE: short_pulse_ff <= csr_wdata;
            olpws_pkg::REG_BYTE_GAP:    byte_gap_ff    <= csr_wdata;
            olpws_pkg::REG_END_GAP:     end_gap_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_level = out_ff.line_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_frame_done = out_ff.frame_done;
   assign rsp_rejected   = out_ff.rejected;

endmodule

@@ sv/olpws_checker.sv @@
// ----------------------------------------------------------------------------
// One-line pulse-width word sender: port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "one_line_pulse_width_word_sender_unit_macros.svh"

module olpws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_kind,
   input logic [olpws_pkg::WordWidth-1:0]   req_data_word,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_line_level,
   input logic                              rsp_busy_res,
   input logic                              rsp_frame_done,
   input logic                              rsp_rejected,
   input logic                              csr_we,
   input logic [olpws_pkg::IdxWidth-1:0]    csr_index,
   input logic [olpws_pkg::CfgWidth-1:0]    csr_wdata
);

   logic unused_ok;
   assign unused_ok = req_valid ^ req_ready ^ req_kind ^ (^req_data_word) ^ csr_we
                      ^ (^csr_index) ^ (^csr_wdata);

   // a rejected request leaves the frame running
   `OLPWS_ASSERT_IMPLY(a_rej_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res)

   // frame end beat: idle and line released high
   `OLPWS_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_frame_done,
                       !rsp_busy_res && rsp_line_level)

   // idle line is always high
   `OLPWS_ASSERT_IMPLY(a_idle_high, clock, reset, rsp_valid && !rsp_busy_res, rsp_line_level)

   // stalled result beat holds
   `OLPWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_line_level) && $stable(rsp_busy_res)
                      && $stable(rsp_frame_done) && $stable(rsp_rejected))

endmodule

bind one_line_pulse_width_word_sender_unit olpws_checker u_olpws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_kind       (req_kind),
   .req_data_word  (req_data_word),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done),
   .rsp_rejected   (rsp_rejected),
   .csr_we         (csr_we),
   .csr_index      (csr_index),
   .csr_wdata      (csr_wdata)
);
